/* hw/rtl/nep_pkg.sv */
// Shared types and constants for the nibble entropy pool.
package nep_pkg;

    // Ring geometry
    localparam int NIBBLE_SLOTS     = 64;
    localparam int NIBBLES_PER_WORD = 8;
    localparam int NIB_W            = 4;
    localparam int WORD_W           = 32;
    localparam int SLOT_W           = $clog2(NIBBLE_SLOTS);
    localparam int NIB_IDX_W        = $clog2(NIBBLES_PER_WORD);
    localparam int WORD_COUNT       = (NIBBLE_SLOTS + NIBBLES_PER_WORD - 1) / NIBBLES_PER_WORD;
    localparam int MEM_DEPTH        = WORD_COUNT * NIBBLES_PER_WORD;

    // Stream payload widths
    localparam int SAMPLE_W   = 16;
    localparam int OP_W       = 2;
    localparam int HELD_W     = 8;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    // Operation codes carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_RAW     = 2'd1,
        OP_MOD     = 2'd2,
        OP_UNIFORM = 2'd3
    } t_op;

    // Request to the serial remainder unit
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

endpackage

/* hw/rtl/nep_div.sv */
// Bit-serial restoring remainder unit, one quotient bit per cycle.
module nep_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nep_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [nep_pkg::WORD_W-1:0] o_rem
);
    import nep_pkg::*;

    localparam int STEP_W = $clog2(WORD_W);

    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_dvd;
    logic [WORD_W-1:0] r_dsr;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] n_rem;

    // One shift-and-subtract step
    always_comb begin
        trial = {r_rem, r_dvd[WORD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        n_rem = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
    end

    // Control: reset clears busy, done and the step counter only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/nibble_entropy_pool_unit.sv */
// Top level of the nibble entropy pool: ring store, draw sequencer and stream ports.
// Append stores directly; raw and modulo draws pop a word, modulo then reduces it; a uniform
// draw first computes a threshold, pops words until one is accepted, then reduces it.
// One item at a time: the next item is taken on the edge after the result is loaded,
// while that result may still wait in the output register.
// Pops read one nibble a cycle from the store; reductions run in the serial divider.
// Synchronous active-low reset empties the ring and clears all handshake state.
module nibble_entropy_pool_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [nep_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // sample[15:0], upper_bound[47:16]
    input  logic [nep_pkg::OP_W-1:0]        s_axis_tuser,  // op[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [nep_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // success[0], random_value[32:1],
                                                           // pool_full[33], nibbles_held[41:34]
);
    import nep_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_POPCHK,
        S_POP,
        S_CHECK,
        S_MOD,
        S_DONE
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NIBBLE_SLOTS - 1);
    localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W + 1)'(NIBBLE_SLOTS);
    localparam logic [SLOT_W-1:0] WORD_NIBS = SLOT_W'(NIBBLES_PER_WORD);

    t_state                r_state;
    t_op                   r_op;
    logic [WORD_W-1:0]     r_bound;
    logic [WORD_W-1:0]     r_thr;
    logic [WORD_W-1:0]     r_word;
    logic [NIB_IDX_W:0]    r_cnt;
    logic [SLOT_W-1:0]     r_read_slot;
    logic [SLOT_W-1:0]     r_write_slot;
    logic [SLOT_W-1:0]     r_held;
    logic                  r_res_ok;
    logic [WORD_W-1:0]     r_res_val;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    t_div_req              r_div_req;
    logic [NIB_W-1:0]      r_rd_nib;
    logic [NIB_W-1:0]      mem [MEM_DEPTH];

    logic                  accept;
    t_op                   in_op;
    logic [SAMPLE_W-1:0]   in_sample;
    logic [WORD_W-1:0]     in_bound;
    logic                  full;
    logic                  wr_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W:0]       rd_sum;
    logic [SLOT_W-1:0]     n_read_slot;
    logic [SLOT_W-1:0]     n_write_slot;
    logic                  out_free;
    logic                  div_done;
    logic [WORD_W-1:0]     div_rem;

    // Input unpacking and status
    assign in_op     = t_op'(s_axis_tuser);
    assign in_sample = s_axis_tdata[SAMPLE_W-1:0];
    assign in_bound  = s_axis_tdata[SAMPLE_W +: WORD_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign full      = (r_held == LAST_SLOT);
    assign wr_en     = accept && (in_op == OP_APPEND) && !full;
    assign out_free  = !r_out_valid || m_axis_tready;

    // Slot arithmetic: a pop advances eight slots with wrap
    always_comb begin
        rd_sum = {1'b0, r_read_slot} + (SLOT_W + 1)'(NIBBLES_PER_WORD);
        if (rd_sum >= SLOTS_EXT) begin
            rd_sum = rd_sum - SLOTS_EXT;
        end
        n_read_slot  = rd_sum[SLOT_W-1:0];
        n_write_slot = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + 1'b1;
        rd_addr      = {r_read_slot[SLOT_W-1:NIB_IDX_W], r_cnt[NIB_IDX_W-1:0]};
    end

    // Nibble store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_write_slot] <= in_sample[NIB_W-1:0];
        end
        r_rd_nib <= mem[rd_addr];
    end

    nep_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // Draw sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_read_slot     <= '0;
            r_write_slot    <= '0;
            r_held          <= '0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            // output register empties on a transfer unless a new result is loaded
            if (m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= in_op;
                        r_bound   <= in_bound;
                        r_res_ok  <= 1'b0;
                        r_res_val <= '0;
                        case (in_op)
                            OP_APPEND: begin
                                if (!full) begin
                                    r_write_slot <= n_write_slot;
                                    r_held       <= r_held + 1'b1;
                                    r_res_ok     <= 1'b1;
                                end
                                r_state <= S_DONE;
                            end
                            OP_RAW: r_state <= S_POPCHK;
                            OP_MOD: r_state <= (in_bound == '0) ? S_DONE : S_POPCHK;
                            OP_UNIFORM: begin
                                if (in_bound == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    // threshold remainder: (2^32 - bound) mod bound
                                    r_div_req.start    <= 1'b1;
                                    r_div_req.dividend <= '0 - in_bound;
                                    r_div_req.divisor  <= in_bound;
                                    r_state            <= S_THR;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_THR: begin
                    if (div_done) begin
                        r_thr   <= ~div_rem;
                        r_state <= S_POPCHK;
                    end
                end
                S_POPCHK: begin
                    if (r_held < WORD_NIBS) begin
                        r_res_ok <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    // nibbles enter at the top and settle lowest slot lowest
                    if (r_cnt != '0) begin
                        r_word <= {r_rd_nib, r_word[WORD_W-1:NIB_W]};
                    end
                    if (r_cnt == (NIB_IDX_W + 1)'(NIBBLES_PER_WORD)) begin
                        r_read_slot <= n_read_slot;
                        r_held      <= r_held - WORD_NIBS;
                        r_state     <= S_CHECK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHECK: begin
                    if (r_op == OP_RAW) begin
                        r_res_ok  <= 1'b1;
                        r_res_val <= r_word;
                        r_state   <= S_DONE;
                    end else if (r_op == OP_UNIFORM && r_word > r_thr) begin
                        // rejected word stays consumed
                        r_state <= S_POPCHK;
                    end else begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= r_word;
                        r_div_req.divisor  <= r_bound;
                        r_state            <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (div_done) begin
                        r_res_ok  <= 1'b1;
                        r_res_val <= div_rem;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {(OUT_DATA_W - WORD_W - HELD_W - 2)'(0),
                                        HELD_W'(r_held), full, r_res_val, r_res_ok};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= LAST_SLOT)
        else $error("held count exceeds ring capacity");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_held == $past(r_held) + 1'b1)
        else $error("stored sample not counted");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP && r_cnt == (NIB_IDX_W + 1)'(NIBBLES_PER_WORD))
        |=> r_held == $past(r_held) - WORD_NIBS)
        else $error("popped word not removed from count");

    a_pop_enough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> r_held >= WORD_NIBS)
        else $error("pop started with fewer than a word held");

endmodule

/* tb/sv/tb_nibble_entropy_pool_unit.sv */
// Self-checking testbench for the nibble entropy pool unit: stream stimulus, pool predictor, result checker.
`timescale 1ns / 100ps

module tb_nibble_entropy_pool_unit;

    import nep_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 160;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int RING_MAX     = NIBBLE_SLOTS - 1;
    localparam int RX_MODE_LEN  = 97;

    // One result as packed on the master side, success in bit 0
    typedef struct packed {
        logic [HELD_W-1:0] held;
        logic              full;
        logic [WORD_W-1:0] value;
        logic              ok;
    } t_pool_outcome;

    localparam int OUTCOME_W = $bits(t_pool_outcome);

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // sample[15:0], upper_bound[47:16]
    logic [OP_W-1:0]       s_axis_tuser  = '0;  // op[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // success[0], random_value[32:1],
                                                // pool_full[33], nibbles_held[41:34]

    // Predictor copy of the ring
    logic [WORD_W-1:0] pool_mem [WORD_COUNT];
    int unsigned       rd_slot;
    int unsigned       wr_slot;
    int unsigned       held_nibs;

    t_pool_outcome     awaited_outcomes [$];
    int                mismatch_count = 0;
    int                burst_left;
    int                cycle_count = 0;
    int unsigned       rx_tick = 0;
    int                rx_mode = 0;
    logic [15:0]       rx_pattern = '1;

    nibble_entropy_pool_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Pool predictor
    // ---------------------------------------------------------------
    function automatic int unsigned advance_slot(input int unsigned s);
        return (s >= NIBBLE_SLOTS - 1) ? 0 : s + 1;
    endfunction

    function automatic logic ring_is_full();
        return advance_slot(wr_slot) == rd_slot;
    endfunction

    // Pops one whole word; w stays zero when fewer than a word of nibbles is held
    function automatic logic take_pool_word(output logic [WORD_W-1:0] w);
        w = '0;
        if (held_nibs < NIBBLES_PER_WORD) return 1'b0;
        w = pool_mem[rd_slot / NIBBLES_PER_WORD];
        repeat (NIBBLES_PER_WORD) rd_slot = advance_slot(rd_slot);
        held_nibs -= NIBBLES_PER_WORD;
        return 1'b1;
    endfunction

    function automatic t_pool_outcome predict_pool_item(input t_op op,
                                                        input logic [SAMPLE_W-1:0] smp,
                                                        input logic [WORD_W-1:0] bnd);
        t_pool_outcome     res;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] neg_bnd;
        logic [WORD_W-1:0] accept_max;
        int unsigned       word_idx;
        int unsigned       nib_pos;
        res  = '0;
        word = '0;
        case (op)
            OP_APPEND: begin
                // full ring drops the sample
                if (!ring_is_full()) begin
                    word_idx = wr_slot / NIBBLES_PER_WORD;
                    nib_pos  = wr_slot % NIBBLES_PER_WORD;
                    pool_mem[word_idx][nib_pos*NIB_W +: NIB_W] = smp[NIB_W-1:0];
                    wr_slot   = advance_slot(wr_slot);
                    held_nibs = held_nibs + 1;
                    res.ok    = 1'b1;
                end
            end
            OP_RAW: begin
                res.ok    = take_pool_word(word);
                res.value = word;
            end
            default: begin
                // zero bound fails and leaves the pool alone
                if (bnd != '0) begin
                    if (op == OP_MOD) begin
                        res.ok = take_pool_word(word);
                    end else begin
                        // 2^32 mod bound taken as (2^32 - bound) mod bound
                        neg_bnd    = '0 - bnd;
                        accept_max = '1 - (neg_bnd % bnd);
                        res.ok     = take_pool_word(word);
                        while (res.ok && word > accept_max) res.ok = take_pool_word(word);
                    end
                    if (res.ok) res.value = word % bnd;
                end
            end
        endcase
        res.full = ring_is_full();
        res.held = HELD_W'(held_nibs);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Random field pickers
    // ---------------------------------------------------------------
    function automatic logic [WORD_W-1:0] pick_bound();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return WORD_W'($urandom_range(2, 16));
            // roughly half of all words fall above the acceptance limit here
            3: return 32'h8000_0001 + WORD_W'($urandom_range(0, 3));
            4: return 32'hFFFF_FFFF - WORD_W'($urandom_range(0, 3));
            5: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] smp;
        smp = SAMPLE_W'($urandom);
        // all-ones nibbles build words that a uniform draw turns away
        if ($urandom_range(0, 3) == 0) smp[NIB_W-1:0] = '1;
        return smp;
    endfunction

    function automatic t_op pick_draw_op();
        return t_op'($urandom_range(int'(OP_RAW), int'(OP_UNIFORM)));
    endfunction

    // ---------------------------------------------------------------
    // Sender: bursts of transfers with noisy gaps between them
    // ---------------------------------------------------------------
    task automatic send_item(input t_op op, input logic [SAMPLE_W-1:0] smp,
                             input logic [WORD_W-1:0] bnd);
        int          gap;
        logic [63:0] noise;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) begin
                noise = {$urandom, $urandom};
                s_axis_tdata <= noise[IN_DATA_W-1:0];
                s_axis_tuser <= noise[IN_DATA_W +: OP_W];
                @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bnd, smp};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        awaited_outcomes.push_back(predict_pool_item(op, smp, bnd));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Every draw kind on an empty pool
    task automatic test_empty_draws();
        send_item(OP_RAW, 16'h1234, 32'd10);
        send_item(OP_MOD, 16'hFFFF, 32'd5);
        send_item(OP_MOD, 16'h0000, '0);
        send_item(OP_UNIFORM, 16'hABCD, 32'd1);
    endtask

    // Field extremes, zero bounds, and a uniform draw that runs the pool dry
    task automatic test_field_extremes();
        logic [SAMPLE_W-1:0] ext_samples [NIBBLES_PER_WORD];
        ext_samples = '{16'hFFFF, 16'h0000, 16'hFFF0, 16'h000F,
                        16'hA5A5, 16'h5A5A, 16'h8001, 16'h7FFE};
        foreach (ext_samples[i]) send_item(OP_APPEND, ext_samples[i], 32'hFFFF_FFFF);
        send_item(OP_RAW, 16'h0000, '0);
        // word of all ones: only value above the limit for a bound of 2^32-1
        repeat (NIBBLES_PER_WORD) send_item(OP_APPEND, 16'hFFFF, 32'hA5A5_5A5A);
        send_item(OP_MOD, 16'hFFFF, '0);
        send_item(OP_UNIFORM, 16'hFFFF, '0);
        send_item(OP_UNIFORM, 16'h0000, 32'hFFFF_FFFF);
    endtask

    // Fill to the brim, overflow, then draw until less than a word is left
    task automatic test_fill_and_overflow();
        while (held_nibs < RING_MAX) send_item(OP_APPEND, pick_sample(), $urandom);
        repeat (2) send_item(OP_APPEND, pick_sample(), $urandom);
        while (held_nibs >= NIBBLES_PER_WORD) send_item(pick_draw_op(), pick_sample(), pick_bound());
    endtask

    // Mixed traffic in segments that lean towards filling or draining
    task automatic test_random_traffic(input int n_items);
        int sent;
        int seg_left;
        int append_pct;
        sent       = 0;
        seg_left   = 0;
        append_pct = 50;
        while (sent < n_items) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0: append_pct = 85;
                    1: append_pct = 50;
                    default: append_pct = 20;
                endcase
            end
            if ($urandom_range(1, 100) <= append_pct)
                send_item(OP_APPEND, pick_sample(), $urandom);
            else
                send_item(pick_draw_op(), pick_sample(), pick_bound());
            seg_left--;
            sent++;
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker and receiver stalls
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pool_outcome got;
        t_pool_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[OUTCOME_W-1:0];
            if (awaited_outcomes.size() == 0) begin
                $error("unexpected result transfer: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                if (got.ok !== want.ok) begin
                    $error("success: expected %0d, got %0d", want.ok, got.ok);
                    mismatch_count++;
                end
                if (got.value !== want.value) begin
                    $error("random_value: expected %h, got %h", want.value, got.value);
                    mismatch_count++;
                end
                if (got.full !== want.full) begin
                    $error("pool_full: expected %0d, got %0d", want.full, got.full);
                    mismatch_count++;
                end
                if (got.held !== want.held) begin
                    $error("nibbles_held: expected %0d, got %0d", want.held, got.held);
                    mismatch_count++;
                end
                if (m_axis_tdata[OUT_DATA_W-1:OUTCOME_W] !== '0) begin
                    $error("tdata padding: expected 0, got %h",
                           m_axis_tdata[OUT_DATA_W-1:OUTCOME_W]);
                    mismatch_count++;
                end
            end
        end

        // receiver switches stall behaviour now and then
        rx_tick++;
        if (rx_tick % RX_MODE_LEN == 0) begin
            rx_mode    = $urandom_range(0, 3);
            rx_pattern = 16'($urandom);
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= rx_pattern[rx_tick % 16];
            default: m_axis_tready <= ((rx_tick % 32) < 3);
        endcase
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_nibble_entropy_pool_unit: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        rd_slot    = 0;
        wr_slot    = 0;
        held_nibs  = 0;
        burst_left = 0;
        foreach (pool_mem[i]) pool_mem[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_draws();
        test_field_extremes();
        test_fill_and_overflow();
        test_random_traffic(350);

        // let the last results drain
        s_axis_tvalid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_nibble_entropy_pool_unit: done, clean");
        else
            $display("tb_nibble_entropy_pool_unit: done, errors");
        $finish;
    end

endmodule

/* nibble_entropy_pool_unit.f */
hw/rtl/nep_pkg.sv
hw/rtl/nep_div.sv
hw/rtl/nibble_entropy_pool_unit.sv
tb/sv/tb_nibble_entropy_pool_unit.sv
